FILE: rtl/mnp_pkg.sv
// ----------------------------------------------------------------------------
// mnp_pkg
// Shared types and constants for the note on/off pairing block.
// ----------------------------------------------------------------------------
package mnp_pkg;

    localparam int SLOT_COUNT = 129;
    localparam int TIME_WIDTH = 32;
    localparam int NOTE_SLOTS = SLOT_COUNT - 1;
    localparam int IDX_W      = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int VEL_W      = 7;
    localparam int ENTRY_W    = TIME_WIDTH + VEL_W;

    localparam logic [7:0] PITCH_LIMIT = 8'(NOTE_SLOTS);

    typedef enum logic [1:0] {
        CMD_NOTE_ON   = 2'd0,
        CMD_NOTE_OFF  = 2'd1,
        CMD_DAMPER_DN = 2'd2,
        CMD_DAMPER_UP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NOTE   = 2'd0,
        KIND_DAMPER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [27:0] delta_ticks;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
    } evt_t;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  note_pitch;
        logic [6:0]  note_velocity;
        logic [31:0] start_ticks;
        logic [31:0] stop_ticks;
    } res_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] start;
        logic [VEL_W-1:0]      vel;
    } entry_t;

endpackage

FILE: rtl/midi_note_pairing.sv
// ----------------------------------------------------------------------------
// midi_note_pairing
// Pairs note-on/note-off and damper down/up events into timed spans.
// ----------------------------------------------------------------------------
// Events arrive on the evt channel (evt_valid, evt_stall, evt_data), each with
// a delta time that is added to a running tick count before the event acts.
// Note-off and damper-up beats give one span (or an unmatched-off error) on
// the res channel (res_valid, res_stall, res_data); note-on and damper-down
// give nothing. An event is held in the event register, its result in the
// result register. Throughput: one event per cycle unless an event with a
// result waits on a held result, set by the single read-modify-write of the
// note RAM per event, with a forwarding register covering a write and a read
// of the same pitch in back-to-back beats. Reset clears the tick count and
// all pending flags; the note RAM needs no clearing since an entry is only
// read while its pending flag is set. While res is stalled with a result
// held, further events that cause no result still flow; an event that causes
// a result stalls evt until the result register frees.
// ----------------------------------------------------------------------------
module midi_note_pairing (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_stall,
    input  mnp_pkg::evt_t evt_data,
    output logic          res_valid,
    input  logic          res_stall,
    output mnp_pkg::res_t res_data
);

    logic          out_free;
    logic          emit;
    mnp_pkg::res_t emit_data;

    mnp_pair_stage u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_data  (evt_data),
        .out_free  (out_free),
        .emit      (emit),
        .emit_data (emit_data)
    );

    mnp_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (emit_data),
        .free      (out_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

`ifndef NO_ASSERTIONS
    // input backpressure only comes from a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        evt_stall |-> (res_valid && res_stall))
        else $error("evt stalled without a held result");

    a_damper_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.kind == mnp_pkg::KIND_DAMPER)) |->
        ((res_data.note_pitch == 7'd0) && (res_data.note_velocity == 7'd0)))
        else $error("damper span with pitch or velocity set");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.kind == mnp_pkg::KIND_ERROR)) |->
        ((res_data.start_ticks == 32'd0) && (res_data.note_velocity == 7'd0)))
        else $error("unmatched off with start or velocity set");

    // a result taken in a cycle with no new emit leaves the register empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && !emit) |=> !res_valid)
        else $error("result beat repeated");
`endif

endmodule

FILE: rtl/mnp_ram.sv
// ----------------------------------------------------------------------------
// mnp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/mnp_out_buf.sv
// ----------------------------------------------------------------------------
// mnp_out_buf
// Result register between the pairing stage and the result channel.
// ----------------------------------------------------------------------------
module mnp_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  mnp_pkg::res_t load_data,
    output logic          free,
    output logic          res_valid,
    input  logic          res_stall,
    output mnp_pkg::res_t res_data
);

    logic          valid_reg;
    logic          valid_next;
    mnp_pkg::res_t data_reg;

    assign free = !valid_reg || !res_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

FILE: rtl/mnp_pair_stage.sv
// ----------------------------------------------------------------------------
// mnp_pair_stage
// Event register, running tick count, slot tables and pairing logic.
// ----------------------------------------------------------------------------
module mnp_pair_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_stall,
    input  mnp_pkg::evt_t evt_data,
    input  logic          out_free,
    output logic          emit,
    output mnp_pkg::res_t emit_data
);

    logic                          in_valid_reg;
    mnp_pkg::evt_t                 in_reg;
    logic [mnp_pkg::TIME_WIDTH-1:0] run_reg;
    logic [mnp_pkg::TIME_WIDTH-1:0] run_next;
    logic                          pend_reg [mnp_pkg::NOTE_SLOTS];
    logic                          dmp_pend_reg;
    logic [mnp_pkg::TIME_WIDTH-1:0] dmp_start_reg;
    logic                          fwd_hit_reg;
    mnp_pkg::entry_t               fwd_data_reg;

    logic                          accept;
    logic                          advance;
    logic                          has_result;
    logic                          in_range;
    logic [mnp_pkg::IDX_W-1:0]     slot;
    logic [mnp_pkg::IDX_W-1:0]     rd_addr;
    logic                          wr_en;
    mnp_pkg::entry_t               wr_entry;
    logic [mnp_pkg::ENTRY_W-1:0]   ram_rd_data;
    mnp_pkg::entry_t               rd_entry;
    logic                          slot_pend;

    assign accept   = evt_valid && !evt_stall;
    assign run_next = run_reg + mnp_pkg::TIME_WIDTH'(in_reg.delta_ticks);
    assign in_range = {1'b0, in_reg.pitch} < mnp_pkg::PITCH_LIMIT;
    assign slot     = in_reg.pitch[mnp_pkg::IDX_W-1:0];
    assign rd_addr  = evt_data.pitch[mnp_pkg::IDX_W-1:0];

    assign has_result = (in_reg.cmd == mnp_pkg::CMD_NOTE_OFF) ||
                        (in_reg.cmd == mnp_pkg::CMD_DAMPER_UP);
    assign advance    = in_valid_reg && (!has_result || out_free);
    assign evt_stall  = in_valid_reg && !advance;
    assign emit       = advance && has_result;

    assign wr_en          = advance && (in_reg.cmd == mnp_pkg::CMD_NOTE_ON) && in_range;
    assign wr_entry.start = run_next;
    assign wr_entry.vel   = in_reg.velocity;

    // write in the same beat as the read of the next event returns old data
    assign rd_entry  = fwd_hit_reg ? fwd_data_reg : mnp_pkg::entry_t'(ram_rd_data);
    assign slot_pend = in_range && pend_reg[slot];

    mnp_ram #(
        .WIDTH (mnp_pkg::ENTRY_W),
        .DEPTH (mnp_pkg::NOTE_SLOTS)
    ) u_note_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data (mnp_pkg::ENTRY_W'(wr_entry)),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        emit_data.kind          = mnp_pkg::KIND_ERROR;
        emit_data.note_pitch    = 7'd0;
        emit_data.note_velocity = 7'd0;
        emit_data.start_ticks   = 32'd0;
        emit_data.stop_ticks    = 32'(run_next);
        case (in_reg.cmd)
            mnp_pkg::CMD_NOTE_OFF:
            begin
                emit_data.note_pitch = in_reg.pitch;
                if (slot_pend)
                begin
                    emit_data.kind          = mnp_pkg::KIND_NOTE;
                    emit_data.note_velocity = rd_entry.vel;
                    emit_data.start_ticks   = 32'(rd_entry.start);
                end
            end
            mnp_pkg::CMD_DAMPER_UP:
            begin
                if (dmp_pend_reg)
                begin
                    emit_data.kind        = mnp_pkg::KIND_DAMPER;
                    emit_data.start_ticks = 32'(dmp_start_reg);
                end
            end
            default:
            begin
                emit_data.kind = mnp_pkg::KIND_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            run_reg      <= '0;
            dmp_pend_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            for (int i = 0; i < mnp_pkg::NOTE_SLOTS; i++)
            begin
                pend_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (slot == rd_addr);
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                run_reg <= run_next;
                unique case (in_reg.cmd)
                    mnp_pkg::CMD_NOTE_ON:
                    begin
                        if (in_range)
                        begin
                            pend_reg[slot] <= 1'b1;
                        end
                    end
                    mnp_pkg::CMD_NOTE_OFF:
                    begin
                        if (slot_pend)
                        begin
                            pend_reg[slot] <= 1'b0;
                        end
                    end
                    mnp_pkg::CMD_DAMPER_DN:
                    begin
                        dmp_pend_reg <= 1'b1;
                    end
                    mnp_pkg::CMD_DAMPER_UP:
                    begin
                        dmp_pend_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg       <= evt_data;
            fwd_data_reg <= wr_entry;
        end
        if (advance && (in_reg.cmd == mnp_pkg::CMD_DAMPER_DN))
        begin
            dmp_start_reg <= run_next;
        end
    end

endmodule
